### hw/rtl/bcp_pkg.sv
// ============================================================================
// bcp_pkg
// Shared types and constants for the brightness / contrast pixel block.
// ============================================================================
package bcp_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST   = 2'd1;

    // luma weights, sum to 65536
    localparam logic [15:0] WEIGHT_R = 16'd19595;
    localparam logic [15:0] WEIGHT_G = 16'd38470;
    localparam logic [15:0] WEIGHT_B = 16'd7471;

    // level constants
    localparam logic signed [9:0]  MID_LEVEL    = 10'sd127;
    localparam logic signed [9:0]  THRESH_LEVEL = 10'sd128;
    localparam logic signed [7:0]  FULL_SCALE   = 8'sd100;
    localparam logic signed [7:0]  UNITY        = 8'sd1;
    localparam logic signed [8:0]  SHIFT_MAX    = 9'sd255;
    localparam logic signed [8:0]  SHIFT_MIN    = -9'sd256;
    localparam logic [7:0]         PIX_MAX      = 8'd255;
    localparam logic [7:0]         PIX_MIN      = 8'd0;

    // shift table geometry
    localparam int unsigned TBL_DEPTH = 256;
    localparam int unsigned TBL_AW    = 8;

    // divider geometry
    localparam int unsigned DVD_W = 16;
    localparam int unsigned DVS_W = 8;
    localparam int unsigned CNT_W = 4;

    // table write word
    typedef struct packed {
        logic                  en;
        logic [TBL_AW-1:0]     addr;
        logic signed [8:0]     data;
    } shift_wr_t;

    // table builder sequencer
    typedef enum logic [1:0] {
        BLD_IDLE,
        BLD_MUL,
        BLD_START,
        BLD_WAIT
    } build_state_t;

endpackage

### hw/rtl/bcp_shift_div.sv
// ============================================================================
// bcp_shift_div
// Bit-serial signed divider, quotient truncated toward zero.
// ============================================================================
module bcp_shift_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [bcp_pkg::DVD_W-1:0]     dividend,
    input  logic signed [bcp_pkg::DVS_W-1:0]     divisor,
    output logic                                 done,
    output logic signed [bcp_pkg::DVD_W-1:0]     quotient
);
    import bcp_pkg::*;

    logic                run_reg,  run_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg,  cnt_next;
    logic                neg_reg,  neg_next;
    logic [DVS_W-1:0]    rem_reg,  rem_next;
    logic [DVD_W-1:0]    quo_reg,  quo_next;
    logic [DVS_W-1:0]    dvs_reg,  dvs_next;

    logic [DVS_W:0]      trial;
    logic                fits;

    // one quotient bit per cycle, restoring form
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});

        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(DVD_W - 1);
            neg_next = dividend[DVD_W-1] ^ divisor[DVS_W-1];
            rem_next = '0;
            quo_next = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            dvs_next = divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
        end
        else if (run_reg)
        begin
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

### hw/rtl/bcp_table_builder.sv
// ============================================================================
// bcp_table_builder
// Sweeps all intensity levels and writes the per-level color shift table.
// ============================================================================
module bcp_table_builder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 restart,
    input  logic signed [7:0]    brightness,
    input  logic signed [7:0]    contrast,
    output logic                 busy,
    output bcp_pkg::shift_wr_t   tbl_wr
);
    import bcp_pkg::*;

    build_state_t         state_reg, state_next;
    logic [TBL_AW-1:0]    idx_reg,   idx_next;
    logic signed [DVD_W-1:0] num_reg, num_next;

    logic                 c_neg;
    logic                 c_zero;
    logic                 thresh;
    logic signed [7:0]    mul;
    logic signed [7:0]    dvs;
    logic signed [9:0]    bright_ext;
    logic signed [9:0]    base;
    logic signed [17:0]   prod;
    logic signed [9:0]    tsum;
    logic signed [8:0]    thresh_entry;
    logic signed [17:0]   ssum;
    logic signed [8:0]    div_entry;
    logic                 div_start;
    logic                 div_done;
    logic signed [DVD_W-1:0] quotient;
    logic                 last;

    // multiply / divide pair from contrast
    always_comb
    begin
        c_neg      = contrast[7];
        c_zero     = (contrast == 8'sd0);
        thresh     = (contrast == FULL_SCALE);
        mul        = c_neg ? 8'(contrast + FULL_SCALE) : (c_zero ? UNITY : FULL_SCALE);
        dvs        = c_neg ? FULL_SCALE : (c_zero ? UNITY : 8'(FULL_SCALE - contrast));
        bright_ext = {{2{brightness[7]}}, brightness};
        base       = 10'($signed({2'b00, idx_reg}) - MID_LEVEL + (c_neg ? 10'sd0 : bright_ext));
        prod       = $signed({{8{base[9]}}, base}) * $signed({{10{mul[7]}}, mul});
    end

    // entry for threshold mode
    always_comb
    begin
        tsum         = $signed({2'b00, idx_reg}) + bright_ext;
        thresh_entry = (tsum < THRESH_LEVEL) ? SHIFT_MIN : SHIFT_MAX;
    end

    // entry from the quotient, saturated to what can still move a byte
    always_comb
    begin
        ssum = {{2{quotient[DVD_W-1]}}, quotient} + 18'(MID_LEVEL)
             - $signed({10'b0, idx_reg})
             + (c_neg ? {{8{bright_ext[9]}}, bright_ext} : 18'sd0);
        if (ssum < 18'(SHIFT_MIN))
            div_entry = SHIFT_MIN;
        else if (ssum > 18'(SHIFT_MAX))
            div_entry = SHIFT_MAX;
        else
            div_entry = ssum[8:0];
    end

    assign last = (idx_reg == TBL_AW'(TBL_DEPTH - 1));

    // sweep sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        num_next    = num_reg;
        div_start   = 1'b0;
        tbl_wr.en   = 1'b0;
        tbl_wr.addr = idx_reg;
        tbl_wr.data = div_entry;

        case (state_reg)
            BLD_IDLE:
            begin
            end
            BLD_MUL:
            begin
                if (thresh)
                begin
                    tbl_wr.en   = 1'b1;
                    tbl_wr.data = thresh_entry;
                    idx_next    = idx_reg + 1'b1;
                    if (last)
                        state_next = BLD_IDLE;
                end
                else
                begin
                    num_next   = prod[DVD_W-1:0];
                    state_next = BLD_START;
                end
            end
            BLD_START:
            begin
                div_start  = 1'b1;
                state_next = BLD_WAIT;
            end
            BLD_WAIT:
            begin
                if (div_done)
                begin
                    tbl_wr.en = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    state_next = last ? BLD_IDLE : BLD_MUL;
                end
            end
            default:
            begin
                state_next = BLD_IDLE;
            end
        endcase

        // a register write rebuilds the table from level zero
        if (restart)
        begin
            state_next = BLD_MUL;
            idx_next   = '0;
        end
    end

    // sequencer registers, table is built after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BLD_MUL;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // numerator
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
    end

    bcp_shift_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quotient)
    );

    assign busy = (state_reg != BLD_IDLE);

endmodule

### hw/rtl/bcp_pixel_pipe.sv
// ============================================================================
// bcp_pixel_pipe
// Pixel datapath: intensity, shift table lookup, add and clamp.
// ============================================================================
module bcp_pixel_pipe (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bcp_pkg::shift_wr_t   tbl_wr,
    input  logic                 in_valid,
    input  logic [7:0]           red_in,
    input  logic [7:0]           green_in,
    input  logic [7:0]           blue_in,
    input  logic [7:0]           alpha_in,
    output logic                 out_valid,
    output logic [7:0]           red_out,
    output logic [7:0]           green_out,
    output logic [7:0]           blue_out,
    output logic [7:0]           alpha_out
);
    import bcp_pkg::*;

    logic signed [8:0]   shift_mem [TBL_DEPTH];

    logic                s1_valid_reg;
    logic [7:0]          s1_r_reg, s1_g_reg, s1_b_reg, s1_a_reg;
    logic                s2_valid_reg;
    logic [7:0]          s2_r_reg, s2_g_reg, s2_b_reg, s2_a_reg;
    logic signed [8:0]   s2_shift_reg;
    logic                out_valid_reg;
    logic [7:0]          red_reg, green_reg, blue_reg, alpha_reg;
    logic [7:0]          red_next, green_next, blue_next;

    logic [23:0]         wsum;
    logic [TBL_AW-1:0]   inten;

    // weighted intensity, products carried at full width
    always_comb
    begin
        wsum  = 24'(s1_r_reg) * 24'(WEIGHT_R) + 24'(s1_g_reg) * 24'(WEIGHT_G)
              + 24'(s1_b_reg) * 24'(WEIGHT_B);
        inten = wsum[23:16];
    end

    // shift table, written by the builder, read into a register
    always_ff @(posedge clk)
    begin
        if (tbl_wr.en)
            shift_mem[tbl_wr.addr] <= tbl_wr.data;
        s2_shift_reg <= shift_mem[inten];
    end

    function automatic logic [7:0] add_clamp(input logic [7:0] c, input logic signed [8:0] s);
        logic signed [9:0] v;
        v = $signed({2'b00, c}) + {s[8], s};
        if (v < 10'sd0)
            add_clamp = PIX_MIN;
        else if (v > $signed({2'b00, PIX_MAX}))
            add_clamp = PIX_MAX;
        else
            add_clamp = v[7:0];
    endfunction

    // add shift and clamp each color
    always_comb
    begin
        red_next   = add_clamp(s2_r_reg, s2_shift_reg);
        green_next = add_clamp(s2_g_reg, s2_shift_reg);
        blue_next  = add_clamp(s2_b_reg, s2_shift_reg);
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // pixel payload through the stages
    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_r_reg <= red_in;
            s1_g_reg <= green_in;
            s1_b_reg <= blue_in;
            s1_a_reg <= alpha_in;
        end
        s2_r_reg  <= s1_r_reg;
        s2_g_reg  <= s1_g_reg;
        s2_b_reg  <= s1_b_reg;
        s2_a_reg  <= s1_a_reg;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        alpha_reg <= s2_a_reg;
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;
    assign alpha_out = alpha_reg;

endmodule

### hw/rtl/brightness_contrast_pixel_top.sv
// ============================================================================
// brightness_contrast_pixel_top
// Brightness / contrast adjustment of one RGBA pixel per word.
// ============================================================================
// A pixel word is taken when start is high and busy is low; its result is
// on the outputs for exactly one cycle, marked by done, once it has passed
// the input, lookup and output registers; the receiver cannot stall it.
// One pixel is taken every cycle while busy is low. The color shift for
// each of the 256 intensity levels lives in a table that is rebuilt after
// reset and after every write to brightness or contrast; busy stays high
// while that happens. In threshold mode (contrast 100) a rebuild writes
// each entry directly; otherwise the 16-step serial divider computes one
// table entry at a time. Register writes are always taken (cfg_ready is
// tied high); indexes other than brightness and contrast are ignored.
module brightness_contrast_pixel_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [7:0]                       red_in,
    input  logic [7:0]                       green_in,
    input  logic [7:0]                       blue_in,
    input  logic [7:0]                       alpha_in,
    output logic                             done,
    output logic [7:0]                       red_out,
    output logic [7:0]                       green_out,
    output logic [7:0]                       blue_out,
    output logic [7:0]                       alpha_out,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bcp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                       cfg_data
);
    import bcp_pkg::*;

    logic signed [7:0]   brightness_reg, brightness_next;
    logic signed [7:0]   contrast_reg,   contrast_next;
    logic                cfg_hit;
    logic                build_busy;
    logic                accept;
    shift_wr_t           tbl_wr;

    // register write decode
    always_comb
    begin
        brightness_next = brightness_reg;
        contrast_next   = contrast_reg;
        cfg_hit         = 1'b0;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BRIGHTNESS:
                begin
                    brightness_next = $signed(cfg_data);
                    cfg_hit         = 1'b1;
                end
                CFG_CONTRAST:
                begin
                    contrast_next = $signed(cfg_data);
                    cfg_hit       = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 8'sd0;
            contrast_reg   <= 8'sd0;
        end
        else
        begin
            brightness_reg <= brightness_next;
            contrast_reg   <= contrast_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = build_busy;
    assign accept    = start && !build_busy;

    bcp_table_builder u_builder (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_hit),
        .brightness (brightness_reg),
        .contrast   (contrast_reg),
        .busy       (build_busy),
        .tbl_wr     (tbl_wr)
    );

    bcp_pixel_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .tbl_wr    (tbl_wr),
        .in_valid  (accept),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .out_valid (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Testbench for brightness_contrast_pixel_top.
// ============================================================================
// Pixel words go in through the start/busy handshake. For each accepted word,
// a local predictor computes the expected output pixel from the current
// brightness and contrast levels and queues it. Every done strobe is checked
// field by field against the oldest queued pixel. Levels are changed only
// with nothing in flight, and busy is allowed to clear after each table
// rebuild. A directed pass covers the extremes, threshold mode, out-of-range
// levels and unused register indexes. Random traffic then runs in three
// phases of source idling.
// ============================================================================
module tb;
    import bcp_pkg::*;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic done;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0] cfg_data;

    // local copy of the level registers
    logic signed [7:0] cur_brightness;
    logic signed [7:0] cur_contrast;

    pixel_t expected_pixels[$];
    pixel_t want_pixel;
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int level_writes = 0;
    int idle_pct = 0;

    brightness_contrast_pixel_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // run limit, far beyond the slowest correct run
    initial
    begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] clamp_level(int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // expected output pixel for the current levels
    function automatic pixel_t predict_pixel(logic [7:0] r, logic [7:0] g,
                                             logic [7:0] b, logic [7:0] a);
        int luma;
        int br;
        int ct;
        int mul;
        int dv;
        int shift;
        logic [7:0] gray;
        pixel_t p;
        br = cur_brightness;
        ct = cur_contrast;
        luma = (7471 * int'(b) + 38470 * int'(g) + 19595 * int'(r)) >> 16;
        if (ct < 0)
        begin
            mul = ct + 100;
            dv = 100;
        end
        else if (ct > 0)
        begin
            mul = 100;
            dv = 100 - ct;
        end
        else
        begin
            mul = 1;
            dv = 1;
        end
        p.alpha = a;
        // hard threshold at contrast 100
        if (dv == 0)
        begin
            gray = (luma + br < 128) ? 8'd0 : 8'd255;
            p.red = gray;
            p.green = gray;
            p.blue = gray;
            return p;
        end
        if (dv == 100)
            shift = (luma - 127) * mul / dv + 127 - luma + br;
        else
            shift = (luma - 127 + br) * mul / dv + 127 - luma;
        p.red = clamp_level(int'(r) + shift);
        p.green = clamp_level(int'(g) + shift);
        p.blue = clamp_level(int'(b) + shift);
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
        if (errors < MAX_REPORTS)
            $display("%0t ns mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("unexpected result word", 8'd0, red_out);
            else
            begin
                want_pixel = expected_pixels.pop_front();
                results_seen++;
                if (red_out !== want_pixel.red)
                    report_mismatch("red", want_pixel.red, red_out);
                if (green_out !== want_pixel.green)
                    report_mismatch("green", want_pixel.green, green_out);
                if (blue_out !== want_pixel.blue)
                    report_mismatch("blue", want_pixel.blue, blue_out);
                if (alpha_out !== want_pixel.alpha)
                    report_mismatch("alpha", want_pixel.alpha, alpha_out);
            end
        end
    end

    // send one pixel word, with random idle cycles ahead of it
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] a);
        pixel_t p;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        p = predict_pixel(r, g, b, a);
        start <= 1'b1;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        alpha_in <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_pixels.push_back(p);
        items_sent++;
    endtask

    // hold off until every queued pixel has come back
    task automatic wait_drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
    endtask

    // register write with the pipeline empty, then wait out the rebuild
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        wait_drain();
        repeat (4) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_BRIGHTNESS: cur_brightness = data;
            CFG_CONTRAST:   cur_contrast = data;
            default:        ;
        endcase
        level_writes++;
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic set_levels(input logic signed [7:0] br, input logic signed [7:0] ct);
        write_reg(CFG_BRIGHTNESS, br);
        write_reg(CFG_CONTRAST, ct);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(11))
            0:       return -8'sd100;
            1:       return 8'sd100;
            2:       return -8'sd128;
            3:       return 8'sd127;
            4:       return 8'sd0;
            5:       return 8'($urandom_range(255));
            default: return 8'($urandom_range(200) - 100);
        endcase
    endfunction

    // reset levels: brightness and contrast both zero
    task automatic test_default_levels();
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0, 8'hA5);
        send_pixel(8'd0, 8'd255, 8'd0, 8'h5A);
        send_pixel(8'd0, 8'd0, 8'd255, 8'h0F);
        send_pixel(8'd128, 8'd128, 8'd128, 8'hF0);
    endtask

    // nominal extremes of both levels
    task automatic test_range_extremes();
        set_levels(8'sd100, 8'sd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd1);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd2);
        set_levels(-8'sd100, -8'sd100);
        send_pixel(8'd255, 8'd40, 8'd0, 8'd3);
        send_pixel(8'd10, 8'd200, 8'd90, 8'd4);
        set_levels(8'sd0, 8'sd99);
        send_pixel(8'd127, 8'd127, 8'd127, 8'd5);
        send_pixel(8'd200, 8'd100, 8'd50, 8'd6);
    endtask

    // contrast 100: gray at either side of the threshold
    task automatic test_threshold_mode();
        set_levels(8'sd0, 8'sd100);
        send_pixel(8'd127, 8'd127, 8'd127, 8'd7);
        send_pixel(8'd128, 8'd128, 8'd128, 8'd8);
        write_reg(CFG_BRIGHTNESS, -8'sd128);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd9);
        write_reg(CFG_BRIGHTNESS, 8'sd127);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd10);
        send_pixel(8'd1, 8'd1, 8'd1, 8'd11);
    endtask

    // levels outside -100..100: negative divide and negative multiply
    task automatic test_out_of_range_levels();
        set_levels(8'sd127, 8'sd127);
        send_pixel(8'd30, 8'd60, 8'd90, 8'd12);
        send_pixel(8'd250, 8'd128, 8'd5, 8'd13);
        set_levels(-8'sd128, -8'sd128);
        send_pixel(8'd30, 8'd60, 8'd90, 8'd14);
        send_pixel(8'd250, 8'd128, 8'd5, 8'd15);
    endtask

    // writes to unused indexes leave both levels alone
    task automatic test_unused_indexes();
        set_levels(8'sd25, -8'sd40);
        write_reg(CFG_SPARE_2, 8'hFF);
        write_reg(CFG_SPARE_3, 8'h64);
        send_pixel(8'd100, 8'd150, 8'd200, 8'd16);
    endtask

    // random pixels and random level changes at a given source idle rate
    task automatic test_random_traffic(input int pct, input int count);
        logic [7:0] v;
        idle_pct = pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 90 == 0)
            begin
                if ($urandom_range(3) == 0)
                    write_reg(CFG_CONTRAST, pick_level());
                else
                    set_levels(pick_level(), pick_level());
            end
            else if (i % 100 == 50)
                wait_drain();
            v = 8'($urandom_range(255));
            case ($urandom_range(7))
                0: send_pixel(v, v, v, 8'($urandom_range(255)));
                1: send_pixel({8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}},
                              {8{$urandom_range(1) == 1}}, 8'($urandom_range(255)));
                default: send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                                    8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        red_in <= 8'd0;
        green_in <= 8'd0;
        blue_in <= 8'd0;
        alpha_in <= 8'd0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BRIGHTNESS;
        cfg_data <= 8'd0;
        cur_brightness = 8'sd0;
        cur_contrast = 8'sd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_levels();
        test_range_extremes();
        test_threshold_mode();
        test_out_of_range_levels();
        test_unused_indexes();
        test_random_traffic(6, 450);
        test_random_traffic(59, 450);
        test_random_traffic(0, 450);

        // drain and let the pipeline settle
        wait_drain();
        repeat (10) @(posedge clk);

        $display("covered %0d pixel words, %0d results checked, %0d register writes",
                 items_sent, results_seen, level_writes);
        $display("levels spanned threshold mode, out-of-range values and unused indexes");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
